FILE: rtl/ksel_pkg.sv
// ksel_pkg: shared types and constants for the rank selection block
// depends on nothing; used by the front, back and top level
`timescale 1ns / 1ps
`default_nettype none

package ksel_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VAL_W     = 32;
	localparam int RANK_W    = 6;
	localparam int CMP_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// flipping the sign bit gives an unsigned key with the same order
	localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic [VAL_W-1:0] key;
		logic             last;
	} ksel_item_t;

	typedef struct packed {
		logic       valid;
		ksel_item_t item;
	} ksel_q_t;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_RD   = 5'b00010,
		B_CMP  = 5'b00100,
		B_FIN  = 5'b01000,
		B_SELW = 5'b10000
	} ksel_state_t;

endpackage

`default_nettype wire

FILE: rtl/ksel_front.sv
// ksel_front: input handshake, key conversion and item queue
// depends on ksel_pkg
`timescale 1ns / 1ps
`default_nettype none

module ksel_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [ksel_pkg::VAL_W-1:0] sample_value,
	input  wire logic                            last_item,
	output ksel_pkg::ksel_q_t                    q_out,
	input  wire logic                            q_pop
);

	ksel_pkg::ksel_item_t           q_mem [ksel_pkg::QDEPTH];
	logic [ksel_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ksel_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ksel_pkg::QCNT_W-1:0]    fill_q;
	logic                           push;
	ksel_pkg::ksel_item_t           new_item;

	assign in_ready = (fill_q != ksel_pkg::QCNT_W'(ksel_pkg::QDEPTH));
	assign push     = in_valid && in_ready;

	// classify: signed value to order key, carry the end-of-set flag
	assign new_item.key  = $unsigned(sample_value) ^ ksel_pkg::SIGN_FLIP;
	assign new_item.last = last_item;

	assign q_out.valid = (fill_q != '0);
	assign q_out.item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			// push and pop together leave the fill level as it is
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (q_pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ksel_back.sv
// ksel_back: sorted element store, insertion engine, rank read and result register
// depends on ksel_pkg
`timescale 1ns / 1ps
`default_nettype none

module ksel_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ksel_pkg::ksel_q_t                 q_in,
	output logic                                   q_pop,
	input  wire logic [ksel_pkg::RANK_W-1:0]       rank_sel,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [ksel_pkg::VAL_W-1:0]      selected_value,
	output logic                                   rank_clamped
);

	logic [ksel_pkg::VAL_W-1:0]  mem [ksel_pkg::MAX_ITEMS];
	logic [ksel_pkg::VAL_W-1:0]  rd_data_q;

	ksel_pkg::ksel_state_t       state_q, state_d;
	logic [ksel_pkg::CNT_W-1:0]  count_q, count_d;
	logic [ksel_pkg::CNT_W-1:0]  pos_q, pos_d;
	logic [ksel_pkg::VAL_W-1:0]  key_q;
	logic                        last_q;
	logic                        clamp_q;

	logic                        mem_we, mem_re;
	logic [ksel_pkg::IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [ksel_pkg::VAL_W-1:0]  mem_wdata;
	logic                        out_load;

	logic [ksel_pkg::CMP_W-1:0]  rank_ext, cnt_ext;
	logic                        clamp;
	logic [ksel_pkg::IDX_W-1:0]  sel_idx;
	logic [ksel_pkg::CNT_W-1:0]  pos_m1;

	logic                        out_valid_q;
	logic [ksel_pkg::VAL_W-1:0]  sel_q;
	logic                        clamped_q;

	assign rank_ext = ksel_pkg::CMP_W'(rank_sel);
	assign cnt_ext  = ksel_pkg::CMP_W'(count_q);
	assign clamp    = (rank_ext >= cnt_ext);
	assign sel_idx  = clamp ? ksel_pkg::IDX_W'(count_q - 1'b1) : ksel_pkg::IDX_W'(rank_sel);
	assign pos_m1   = pos_q - 1'b1;

	assign out_load = (state_q == ksel_pkg::B_SELW) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = pos_q[ksel_pkg::IDX_W-1:0];
		mem_raddr = pos_m1[ksel_pkg::IDX_W-1:0];
		mem_wdata = key_q;
		unique case (state_q)
			ksel_pkg::B_IDLE: begin
				if (q_in.valid) begin
					q_pop = 1'b1;
					pos_d = count_q;
					// full store drops the item but still honors its end flag
					if (count_q == ksel_pkg::CNT_W'(ksel_pkg::MAX_ITEMS)) begin
						state_d = ksel_pkg::B_FIN;
					end else begin
						state_d = ksel_pkg::B_RD;
					end
				end
			end
			ksel_pkg::B_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					count_d = count_q + 1'b1;
					state_d = ksel_pkg::B_FIN;
				end else begin
					mem_re  = 1'b1;
					state_d = ksel_pkg::B_CMP;
				end
			end
			ksel_pkg::B_CMP: begin
				mem_we = 1'b1;
				if (rd_data_q > key_q) begin
					// shift the larger entry up one slot
					mem_wdata = rd_data_q;
					pos_d     = pos_m1;
					state_d   = ksel_pkg::B_RD;
				end else begin
					count_d = count_q + 1'b1;
					state_d = ksel_pkg::B_FIN;
				end
			end
			ksel_pkg::B_FIN: begin
				if (last_q) begin
					mem_re    = 1'b1;
					mem_raddr = sel_idx;
					state_d   = ksel_pkg::B_SELW;
				end else begin
					state_d = ksel_pkg::B_IDLE;
				end
			end
			ksel_pkg::B_SELW: begin
				if (out_load) begin
					count_d = '0;
					state_d = ksel_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = ksel_pkg::B_IDLE;
			end
		endcase
	end

	// element store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_q  <= q_in.item.key;
			last_q <= q_in.item.last;
		end
		if ((state_q == ksel_pkg::B_FIN) && last_q) begin
			clamp_q <= clamp;
		end
		if (out_load) begin
			sel_q     <= rd_data_q ^ ksel_pkg::SIGN_FLIP;
			clamped_q <= clamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ksel_pkg::B_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_value = $signed(sel_q);
	assign rank_clamped   = clamped_q;

endmodule

`default_nettype wire

FILE: rtl/kth_smallest_select.sv
// kth_smallest_select: top level of the rank selection block
// depends on ksel_pkg, ksel_front and ksel_back
`timescale 1ns / 1ps
`default_nettype none

// Loads one set of signed 32-bit values, one item per handshake, keeps them
// sorted ascending in a 64-entry store, and on the item flagged last_item
// returns the value at zero-based ascending rank rank_select (ties count as
// separate entries; rank set to the middle gives the median). A rank not
// below the set size is clamped to size minus one and rank_clamped is set.
// Values arriving once the store holds 64 entries are dropped, a dropped
// last item still closes the set. After the result the store starts empty.
// Timing: the front queue takes an item every cycle while it has room (four
// entries). The back end inserts each item by walking the store from the
// top: it reads the entry below the free slot, shifts it up one slot while
// it is larger, and writes the item into the freed slot or the bottom slot,
// so a set loaded in descending order costs the most and ascending order the
// least; the next item is taken only once the last is stored. On the final
// item the store is read at the selected rank and the result goes into the
// output register, which holds one result while the next set loads.
// rank_select must be written through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.

module kth_smallest_select (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [ksel_pkg::RANK_W-1:0]         cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [ksel_pkg::VAL_W-1:0]   sample_value,
	input  wire logic                                last_item,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [ksel_pkg::VAL_W-1:0]        selected_value,
	output logic                                     rank_clamped
);

	// rank register, reset to the lowest rank
	logic [ksel_pkg::RANK_W-1:0] rank_select_q;

	// queue view from front to back
	ksel_pkg::ksel_q_t q_link;
	logic              q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_select_q <= '0;
		end else if (cfg_wr_en) begin
			rank_select_q <= cfg_wr_data;
		end
	end

	// front: accepts items, turns values into order keys, queues them
	ksel_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.last_item    (last_item),
		.q_out        (q_link),
		.q_pop        (q_pop)
	);

	// back: insertion into the sorted store, rank read, result register
	ksel_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_in           (q_link),
		.q_pop          (q_pop),
		.rank_sel       (rank_select_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.selected_value (selected_value),
		.rank_clamped   (rank_clamped)
	);

endmodule

`default_nettype wire

FILE: rtl/ksel_checker.sv
// ksel_checker: port-level assertions for kth_smallest_select, bound to the top
// depends on kth_smallest_select ports only
`timescale 1ns / 1ps
`default_nettype none

module ksel_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_item,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] selected_value,
	input wire logic        rank_clamped
);

	// sets closed at the input whose result has not been taken yet
	logic [3:0] pending_q;
	logic       set_in, res_out;

	assign set_in  = in_valid && in_ready && last_item;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			if (set_in && !res_out) begin
				pending_q <= pending_q + 1'b1;
			end else if (res_out && !set_in) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(selected_value)
			&& $stable(rank_clamped))
		else $error("stalled result changed");

	a_result_has_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without a closed set");

	a_rise_has_set: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> pending_q != 4'd0)
		else $error("result appeared with no set pending");

endmodule

bind kth_smallest_select ksel_checker u_ksel_checker (.*);

`default_nettype wire
